/* rtl/cpo_pkg.sv */
// Package for the convex polygon overlap (separating axis) block.
// Holds sizes, beat types and the control structs shared by cpo_dot, cpo_seq and the top.
// No dependencies.
`timescale 1ns / 1ps

package cpo_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int AX_W   = COORD_BITS + 1;
  localparam int PROD_W = AX_W + COORD_BITS;
  localparam int DOT_W  = PROD_W + 1;
  localparam int VTX_W  = 2 * COORD_BITS;

  typedef struct packed {
    logic                         polygon_select;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;
  } in_item_t;

  typedef struct packed {
    logic overlap;
    logic error;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic valid;
    logic sel_b;
    logic first;
  } proj_ctl_t;

  typedef struct packed {
    logic pending;
    logic separated;
  } dot_sts_t;

  typedef struct packed {
    logic             we_a;
    logic             we_b;
    logic [IDX_W-1:0] addr;
    vertex_t          data;
  } ram_wr_t;

endpackage

/* rtl/cpo_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the vertex stores.
`timescale 1ns / 1ps

module cpo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cpo_dot.sv */
// Shared projection unit: dot product of one vertex with the current axis,
// then running min/max per polygon and the interval separation flag.
// Depends on cpo_pkg.
`timescale 1ns / 1ps

module cpo_dot (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cpo_pkg::proj_ctl_t                    ctl_i,
  input  cpo_pkg::vertex_t                      vtx_i,
  input  logic signed [cpo_pkg::AX_W-1:0]       nx_i,
  input  logic signed [cpo_pkg::AX_W-1:0]       ny_i,
  output cpo_pkg::dot_sts_t                     sts_o
);
  import cpo_pkg::*;

  proj_ctl_t                 s1_q;
  logic signed [PROD_W-1:0]  px_q, py_q;
  logic signed [DOT_W-1:0]   dot;
  logic signed [DOT_W-1:0]   lo_a_q, hi_a_q, lo_b_q, hi_b_q;

  assign dot = DOT_W'(px_q) + DOT_W'(py_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= PROD_W'(nx_i) * PROD_W'(vtx_i.x);
    py_q <= PROD_W'(ny_i) * PROD_W'(vtx_i.y);
    if (s1_q.valid) begin
      if (s1_q.sel_b) begin
        if (s1_q.first || dot < lo_b_q) lo_b_q <= dot;
        if (s1_q.first || dot > hi_b_q) hi_b_q <= dot;
      end else begin
        if (s1_q.first || dot < lo_a_q) lo_a_q <= dot;
        if (s1_q.first || dot > hi_a_q) hi_a_q <= dot;
      end
    end
  end

  assign sts_o.pending   = s1_q.valid;
  assign sts_o.separated = (lo_a_q > hi_b_q) || (lo_b_q > hi_a_q);

endmodule

/* rtl/cpo_seq.sv */
// Sequencer: vertex loading, edge axis setup and projection sweep over the
// vertex RAMs, result beat. Depends on cpo_pkg; drives cpo_ram and cpo_dot.
`timescale 1ns / 1ps

module cpo_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  cpo_pkg::in_item_t                 item_i,
  output logic                              busy_o,
  output logic                              done_o,
  output cpo_pkg::out_item_t                result_o,
  output cpo_pkg::ram_wr_t                  wr_o,
  output logic [cpo_pkg::IDX_W-1:0]         raddr_o,
  input  cpo_pkg::vertex_t                  rdata_a_i,
  input  cpo_pkg::vertex_t                  rdata_b_i,
  output cpo_pkg::proj_ctl_t                proj_o,
  output cpo_pkg::vertex_t                  proj_vtx_o,
  output logic signed [cpo_pkg::AX_W-1:0]   nx_o,
  output logic signed [cpo_pkg::AX_W-1:0]   ny_o,
  input  cpo_pkg::dot_sts_t                 sts_i
);
  import cpo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RD_J, S_RD_I, S_AXIS, S_PROJ, S_DRAIN
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                    ovf_q, ovf_d;
  logic                    poly_q, poly_d;
  logic                    sel_q, sel_d;
  logic [IDX_W-1:0]        edge_q, edge_d;
  logic [IDX_W-1:0]        k_q, k_d;
  proj_ctl_t               iss_q, iss_d;
  logic                    strobe_q, strobe_d;
  out_item_t               res_q, res_d;
  vertex_t                 prev_q, prev_d;
  logic signed [AX_W-1:0]  nx_q, nx_d, ny_q, ny_d;

  logic                    accept;
  logic [IDX_W-1:0]        last_p, last_s;
  vertex_t                 edge_vtx;
  logic signed [AX_W-1:0]  ex, ey;

  assign accept   = start_i && (state_q == S_IDLE);
  assign last_p   = IDX_W'((poly_q ? cnt_b_q : cnt_a_q) - CNT_W'(1));
  assign last_s   = IDX_W'((sel_q ? cnt_b_q : cnt_a_q) - CNT_W'(1));
  assign edge_vtx = poly_q ? rdata_b_i : rdata_a_i;
  assign ex       = AX_W'(edge_vtx.x) - AX_W'(prev_q.x);
  assign ey       = AX_W'(edge_vtx.y) - AX_W'(prev_q.y);

  always_comb begin
    state_d  = state_q;
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    ovf_d    = ovf_q;
    poly_d   = poly_q;
    sel_d    = sel_q;
    edge_d   = edge_q;
    k_d      = k_q;
    iss_d    = '0;
    strobe_d = 1'b0;
    res_d    = res_q;
    prev_d   = prev_q;
    nx_d     = nx_q;
    ny_d     = ny_q;
    wr_o     = '0;
    raddr_o  = '0;
    wr_o.data.x = item_i.vertex_x;
    wr_o.data.y = item_i.vertex_y;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.polygon_select) begin
            if (cnt_b_q == CNT_W'(MAX_VERTICES)) begin
              ovf_d = 1'b1;
            end else begin
              wr_o.we_b = 1'b1;
              wr_o.addr = cnt_b_q[IDX_W-1:0];
              cnt_b_d   = cnt_b_q + CNT_W'(1);
            end
          end else begin
            if (cnt_a_q == CNT_W'(MAX_VERTICES)) begin
              ovf_d = 1'b1;
            end else begin
              wr_o.we_a = 1'b1;
              wr_o.addr = cnt_a_q[IDX_W-1:0];
              cnt_a_d   = cnt_a_q + CNT_W'(1);
            end
          end
          if (item_i.last_vertex) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ovf_q || cnt_a_q == '0 || cnt_b_q == '0) begin
          strobe_d      = 1'b1;
          res_d.overlap = 1'b0;
          res_d.error   = 1'b1;
          state_d       = S_IDLE;
        end else begin
          poly_d  = 1'b0;
          edge_d  = '0;
          state_d = S_RD_J;
        end
      end
      S_RD_J: begin
        raddr_o = (edge_q == '0) ? last_p : edge_q - IDX_W'(1);
        state_d = S_RD_I;
      end
      S_RD_I: begin
        raddr_o = edge_q;
        prev_d  = edge_vtx;
        state_d = S_AXIS;
      end
      S_AXIS: begin
        nx_d    = -ey;
        ny_d    = ex;
        sel_d   = 1'b0;
        k_d     = '0;
        state_d = S_PROJ;
      end
      S_PROJ: begin
        raddr_o     = k_q;
        iss_d.valid = 1'b1;
        iss_d.sel_b = sel_q;
        iss_d.first = (k_q == '0);
        if (k_q == last_s) begin
          if (!sel_q) begin
            sel_d = 1'b1;
            k_d   = '0;
          end else begin
            state_d = S_DRAIN;
          end
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!iss_q.valid && !sts_i.pending) begin
          if (sts_i.separated) begin
            strobe_d      = 1'b1;
            res_d.overlap = 1'b0;
            res_d.error   = 1'b0;
            state_d       = S_IDLE;
          end else if (edge_q == last_p) begin
            if (!poly_q) begin
              poly_d  = 1'b1;
              edge_d  = '0;
              state_d = S_RD_J;
            end else begin
              strobe_d      = 1'b1;
              res_d.overlap = 1'b1;
              res_d.error   = 1'b0;
              state_d       = S_IDLE;
            end
          end else begin
            edge_d  = edge_q + IDX_W'(1);
            state_d = S_RD_J;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (strobe_d) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      ovf_q    <= 1'b0;
      poly_q   <= 1'b0;
      sel_q    <= 1'b0;
      edge_q   <= '0;
      k_q      <= '0;
      iss_q    <= '0;
      strobe_q <= 1'b0;
      res_q    <= '0;
      prev_q   <= '0;
      nx_q     <= '0;
      ny_q     <= '0;
    end else begin
      state_q  <= state_d;
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
      ovf_q    <= ovf_d;
      poly_q   <= poly_d;
      sel_q    <= sel_d;
      edge_q   <= edge_d;
      k_q      <= k_d;
      iss_q    <= iss_d;
      strobe_q <= strobe_d;
      res_q    <= res_d;
      prev_q   <= prev_d;
      nx_q     <= nx_d;
      ny_q     <= ny_d;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = strobe_q;
  assign result_o   = res_q;
  assign proj_o     = iss_q;
  assign proj_vtx_o = iss_q.sel_b ? rdata_b_i : rdata_a_i;
  assign nx_o       = nx_q;
  assign ny_o       = ny_q;

  a_err_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && res_q.error |-> !res_q.overlap)
    else $error("error beat carries overlap");

  a_cleared_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> cnt_a_q == '0 && cnt_b_q == '0 && !ovf_q)
    else $error("vertex store not emptied after result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_a_q <= CNT_W'(MAX_VERTICES) && cnt_b_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_issue_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q.valid |-> state_q == S_PROJ || state_q == S_DRAIN)
    else $error("projection read outside sweep");

  a_beat_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(strobe_q) |-> $past(busy_o))
    else $error("result beat without a running test");

endmodule

/* rtl/convex_polygon_overlap_sat_top.sv */
// Top level of the 2D convex polygon overlap block (separating axis test).
// Depends on cpo_pkg, cpo_ram, cpo_dot and cpo_seq.
//
//   channel  | handshake           | beat
//   ---------+---------------------+---------------------------------------
//   vertex   | start_i, busy_o     | item_i: polygon_select, x, y, last
//   result   | done_o (one cycle)  | result_o: overlap, error
//
// A vertex is taken when start_i is high and busy_o is low; vertices may
// arrive every cycle while the block is idle. The last vertex makes the block
// busy, only for the check on an error, else for the sweep: every edge axis
// sweeps all Na+Nb vertices through the single read port of the vertex RAMs
// and the one dot unit. done_o pulses for one cycle as busy_o drops; the
// receiver cannot stall it. Reset is asynchronous and empties the vertex store.
`timescale 1ns / 1ps

module convex_polygon_overlap_sat_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  cpo_pkg::in_item_t   item_i,
  output logic                busy_o,
  output logic                done_o,
  output cpo_pkg::out_item_t  result_o
);
  import cpo_pkg::*;

  ram_wr_t                 wr;
  logic [IDX_W-1:0]        raddr;
  logic [VTX_W-1:0]        rdata_a, rdata_b;
  proj_ctl_t               proj;
  vertex_t                 proj_vtx;
  logic signed [AX_W-1:0]  nx, ny;
  dot_sts_t                sts;

  cpo_ram #(
    .WIDTH(VTX_W),
    .DEPTH(MAX_VERTICES)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr.we_a),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  cpo_ram #(
    .WIDTH(VTX_W),
    .DEPTH(MAX_VERTICES)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr.we_b),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  cpo_dot u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (proj),
    .vtx_i  (proj_vtx),
    .nx_i   (nx),
    .ny_i   (ny),
    .sts_o  (sts)
  );

  cpo_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .result_o   (result_o),
    .wr_o       (wr),
    .raddr_o    (raddr),
    .rdata_a_i  (vertex_t'(rdata_a)),
    .rdata_b_i  (vertex_t'(rdata_b)),
    .proj_o     (proj),
    .proj_vtx_o (proj_vtx),
    .nx_o       (nx),
    .ny_o       (ny),
    .sts_i      (sts)
  );

endmodule
